FILE: design/dpm_pkg.sv
// shared constants and types for the binary64 multiplier
package dpm_pkg;
    localparam int unsigned MANT_W   = 52;
    localparam int unsigned SIG_W    = 53;
    localparam int unsigned EXP_W    = 11;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned N_CELLS  = 14;   // ceil(53 / 4)
    localparam int unsigned PROD_W   = 2 * SIG_W;
    localparam logic [EXP_W-1:0] EXP_MAX  = 11'h7ff;
    localparam logic [12:0]      EXP_BIAS = 13'd1023;
    localparam logic [WORD_W-1:0] INF_BITS  = 64'h7ff0_0000_0000_0000;
    localparam logic [WORD_W-1:0] QNAN_BITS = 64'h7ff8_0000_0000_0000;

    // item context carried along the cell chain
    typedef struct packed {
        logic              special;
        logic [WORD_W-1:0] special_bits;
        logic              sign;
        logic [12:0]       exp_sum;   // signed, sum minus bias
    } t_ctx;
endpackage

FILE: design/dpm_cell.sv
// one cell of the multiplier chain: adds one 4-bit digit partial product
module dpm_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [dpm_pkg::SIG_W-1:0]      i_mcand,
    input  logic [dpm_pkg::SIG_W-1:0]      i_mplier,
    input  logic [dpm_pkg::PROD_W-1:0]     i_acc,
    input  dpm_pkg::t_ctx                  i_ctx,
    input  logic [5:0]                     i_shift,
    output logic                           o_valid,
    output logic [dpm_pkg::SIG_W-1:0]      o_mcand,
    output logic [dpm_pkg::SIG_W-1:0]      o_mplier,
    output logic [dpm_pkg::PROD_W-1:0]     o_acc,
    output dpm_pkg::t_ctx                  o_ctx
);
    import dpm_pkg::*;

    logic [DIGIT_W-1:0]  w_digit;
    logic [PROD_W-1:0]   w_pp;
    logic                r_valid;
    logic [SIG_W-1:0]    r_mcand;
    logic [SIG_W-1:0]    r_mplier;
    logic [PROD_W-1:0]   r_acc;
    t_ctx                r_ctx;

    // partial product of this cell's digit
    assign w_digit = DIGIT_W'(i_mplier >> i_shift);
    assign w_pp    = PROD_W'(i_mcand) * PROD_W'(w_digit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // payload moves to the neighbor every cycle
    always_ff @(posedge i_clk) begin
        r_mcand  <= i_mcand;
        r_mplier <= i_mplier;
        r_acc    <= i_acc + (w_pp << i_shift);
        r_ctx    <= i_ctx;
    end

    assign o_valid  = r_valid;
    assign o_mcand  = r_mcand;
    assign o_mplier = r_mplier;
    assign o_acc    = r_acc;
    assign o_ctx    = r_ctx;
endmodule

FILE: design/double_precision_multiplier_core.sv
// top level of the binary64 multiplier: decode, cell chain, normalize
//
// channel | signals                              | handshake
// input   | i_operand_a, i_operand_b             | start, busy
// result  | o_product, o_exponent_wrapped        | o_done strobe, no stall
//
// one transfer per cycle; each result passes through the 14-cell chain
// and then the normalize register before it appears.
// busy is always low. synchronous active-low reset clears valid bits.
module double_precision_multiplier_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [dpm_pkg::WORD_W-1:0]  i_operand_a,
    input  logic [dpm_pkg::WORD_W-1:0]  i_operand_b,
    output logic                        o_done,
    output logic [dpm_pkg::WORD_W-1:0]  o_product,
    output logic                        o_exponent_wrapped
);
    import dpm_pkg::*;

    logic [EXP_W-1:0]  w_ea, w_eb;
    logic [MANT_W-1:0] w_fa, w_fb;
    logic              w_inf, w_nan_a, w_nan_b;
    t_ctx              w_ctx0;
    logic [12:0]       w_sum;

    logic              c_valid [0:N_CELLS];
    logic [SIG_W-1:0]  c_mcand [0:N_CELLS];
    logic [SIG_W-1:0]  c_mplier[0:N_CELLS];
    logic [PROD_W-1:0] c_acc   [0:N_CELLS];
    t_ctx              c_ctx   [0:N_CELLS];

    logic [SIG_W:0]    w_m;
    logic [SIG_W-1:0]  w_mr;
    logic [12:0]       w_exp;
    logic              r_done;
    logic [WORD_W-1:0] r_product;
    logic              r_wrapped;

    assign busy = 1'b0;

    // field decode and special cases
    assign w_ea    = i_operand_a[62:52];
    assign w_eb    = i_operand_b[62:52];
    assign w_fa    = i_operand_a[MANT_W-1:0];
    assign w_fb    = i_operand_b[MANT_W-1:0];
    assign w_inf   = (w_ea == EXP_MAX && w_fa == '0) || (w_eb == EXP_MAX && w_fb == '0);
    assign w_nan_a = (w_ea == EXP_MAX) && (w_fa != '0);
    assign w_nan_b = (w_eb == EXP_MAX) && (w_fb != '0);
    assign w_sum   = 13'(w_ea) + 13'(w_eb);

    always_comb begin
        w_ctx0.sign    = i_operand_a[63] ^ i_operand_b[63];
        w_ctx0.special = w_inf || w_nan_a || w_nan_b;
        w_ctx0.exp_sum = (w_sum == '0) ? 13'd0 : w_sum - EXP_BIAS;
        if (w_inf) begin
            w_ctx0.special_bits = INF_BITS | {w_ctx0.sign, 63'd0};
        end else if (w_nan_a) begin
            w_ctx0.special_bits = QNAN_BITS | {i_operand_a[63], 63'd0};
        end else begin
            w_ctx0.special_bits = QNAN_BITS | {i_operand_b[63], 63'd0};
        end
    end

    assign c_valid[0]  = start;
    assign c_mcand[0]  = {1'b1, w_fa};
    assign c_mplier[0] = {1'b1, w_fb};
    assign c_acc[0]    = '0;
    assign c_ctx[0]    = w_ctx0;

    // chain of digit cells
    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        dpm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (c_valid[g]),
            .i_mcand  (c_mcand[g]),
            .i_mplier (c_mplier[g]),
            .i_acc    (c_acc[g]),
            .i_ctx    (c_ctx[g]),
            .i_shift  (6'(g * DIGIT_W)),
            .o_valid  (c_valid[g+1]),
            .o_mcand  (c_mcand[g+1]),
            .o_mplier (c_mplier[g+1]),
            .o_acc    (c_acc[g+1]),
            .o_ctx    (c_ctx[g+1])
        );
    end

    // normalize and pack
    assign w_m   = c_acc[N_CELLS][PROD_W-1:MANT_W];
    assign w_mr  = SIG_W'((w_m + 54'd1) >> 1);
    assign w_exp = c_ctx[N_CELLS].exp_sum + 13'(w_m[SIG_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= c_valid[N_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ctx[N_CELLS].special) begin
            r_product <= c_ctx[N_CELLS].special_bits;
            r_wrapped <= 1'b0;
        end else begin
            r_product <= {c_ctx[N_CELLS].sign, w_exp[EXP_W-1:0],
                          w_m[SIG_W] ? w_mr[MANT_W-1:0] : w_m[MANT_W-1:0]};
            r_wrapped <= (w_exp[12:EXP_W] != 2'b00);
        end
    end

    assign o_done             = r_done;
    assign o_product          = r_product;
    assign o_exponent_wrapped = r_wrapped;

`ifndef SYNTHESIS
    // result strobe follows the chain's output valid through the normalize register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_valid[N_CELLS] |=> o_done) else $error("missing result strobe");
    // special results never flag a wrap
    a_nowrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_valid[N_CELLS] && c_ctx[N_CELLS].special) |=> !o_exponent_wrapped)
        else $error("wrap flagged on special result");
    a_busy: assert property (@(posedge i_clk) !busy) else $error("busy raised");
`endif
endmodule
